@@ rtl/bis_pkg.sv @@
// bis_pkg: constants, types and helper functions of the bilinear image sampler
// used by the channel interfaces, the blend datapath and the top level
// no dependencies
package bis_pkg;

    // image store geometry and number formats
    localparam int MAX_WIDTH       = 512;
    localparam int MAX_HEIGHT      = 512;
    localparam int PIXEL_BITS      = 16;
    localparam int COORD_FRAC_BITS = 8;

    // fixed field widths of the channels
    localparam int OPCODE_W      = 1;
    localparam int PIX_POS_W     = 9;
    localparam int VALUE_FIELD_W = 16;
    localparam int COORD_W       = 18;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int DIM_FIELD_W   = 10;
    localparam int OUT_W         = 40;
    localparam int OUT_FRAC      = 16;

    // coordinate and dimension widths
    localparam int COL_W   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W   = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DIM_W_X = $clog2(MAX_WIDTH + 1);
    localparam int DIM_W_Y = $clog2(MAX_HEIGHT + 1);
    localparam int INT_W   = COORD_W - COORD_FRAC_BITS;
    localparam int EXT_A   = (INT_W > DIM_W_X) ? INT_W : DIM_W_X;
    localparam int EXT_W   = (EXT_A > DIM_W_Y) ? EXT_A : DIM_W_Y;
    localparam int FRAC_W  = COORD_FRAC_BITS + 1;

    // four banks split by row and column parity
    localparam int NUM_BANKS   = 4;
    localparam int NUM_CORNERS = 4;
    localparam int BANK_SEL_W  = 2;
    localparam int BANK_COLS   = (MAX_WIDTH + 1) / 2;
    localparam int BANK_ROWS   = (MAX_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH  = BANK_COLS * BANK_ROWS;
    localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int PIX_W       = PIXEL_BITS + 1;

    // blend datapath widths
    localparam int CMP_W = PIXEL_BITS + VALUE_FIELD_W;
    localparam int DIFF_W = PIXEL_BITS + 1;
    localparam int V_W   = PIXEL_BITS + COORD_FRAC_BITS + 3;
    localparam int D_W   = V_W + 1;
    localparam int R_W   = V_W + COORD_FRAC_BITS + 3;
    localparam int SHL   = (2 * COORD_FRAC_BITS <= OUT_FRAC) ? OUT_FRAC - 2 * COORD_FRAC_BITS : 0;
    localparam int SHR   = (2 * COORD_FRAC_BITS > OUT_FRAC) ? 2 * COORD_FRAC_BITS - OUT_FRAC : 0;
    localparam int RND_C = (SHR > 0) ? (1 << ((SHR > 0) ? SHR - 1 : 0)) : 0;
    localparam int S_W   = R_W + SHL;
    localparam int SAT_W = ((S_W > OUT_W) ? S_W : OUT_W) + 1;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_BLANK_VALUE  = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic                         invalid;
        logic signed [PIXEL_BITS-1:0] value;
    } t_pixel;

    typedef struct packed {
        logic              outside;
        logic              ix0;
        logic              iy0;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
    } t_query_meta;

    typedef struct packed {
        logic load_mid;
        logic load_out;
    } t_blend_ctrl;

    function automatic int clamp_dim(int v, int maxv);
        int r;
        r = v;
        if (v < 2) begin
            r = 2;
        end else if (v > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

    localparam int RST_WIDTH  = clamp_dim(512, MAX_WIDTH);
    localparam int RST_HEIGHT = clamp_dim(512, MAX_HEIGHT);

    // truncate or sign-extend a written sample to the stored pixel width
    function automatic logic signed [PIXEL_BITS-1:0] fit_pixel(
        logic signed [VALUE_FIELD_W-1:0] v
    );
        logic signed [PIXEL_BITS+VALUE_FIELD_W-1:0] ext;
        ext = (PIXEL_BITS + VALUE_FIELD_W)'(v);
        return ext[PIXEL_BITS-1:0];
    endfunction

endpackage

@@ rtl/bis_if.sv @@
// bis_if: valid/ready channel interfaces of the bilinear image sampler
// item channel, configuration write channel and sample result channel
// depends on bis_pkg
interface bis_item_if;
    import bis_pkg::*;
    logic                            valid;
    logic                            ready;
    logic [OPCODE_W-1:0]             opcode;
    logic [PIX_POS_W-1:0]            pixel_col;
    logic [PIX_POS_W-1:0]            pixel_row;
    logic signed [VALUE_FIELD_W-1:0] pixel_value;
    logic                            pixel_invalid;
    logic signed [COORD_W-1:0]       coord_x;
    logic signed [COORD_W-1:0]       coord_y;

    modport source (
        output valid, opcode, pixel_col, pixel_row, pixel_value, pixel_invalid,
               coord_x, coord_y,
        input  ready
    );
    modport sink (
        input  valid, opcode, pixel_col, pixel_row, pixel_value, pixel_invalid,
               coord_x, coord_y,
        output ready
    );
endinterface

interface bis_cfg_if;
    import bis_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

interface bis_sample_if;
    import bis_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] sample_value;
    logic                    sample_blank;

    modport source (output valid, sample_value, sample_blank, input ready);
    modport sink (input valid, sample_value, sample_blank, output ready);
endinterface

@@ rtl/bis_bank_ram.sv @@
// bis_bank_ram: simple dual-port RAM, one write port and one registered read port
// holds one parity bank of the pixel store
// no dependencies
module bis_bank_ram #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 17,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bis_blend.sv @@
// bis_blend: corner unscrambling, missing-data test and two-step bilinear blend
// two register stages: row blends, then column blend with rescale and saturation
// depends on bis_pkg
module bis_blend (
    input  logic                                    i_clk,
    input  bis_pkg::t_blend_ctrl                    i_ctrl,
    input  bis_pkg::t_query_meta                    i_meta,
    input  bis_pkg::t_pixel                         i_bank_data [bis_pkg::NUM_BANKS],
    input  logic signed [bis_pkg::VALUE_FIELD_W-1:0] i_blank_value,
    output logic signed [bis_pkg::OUT_W-1:0]        o_value,
    output logic                                    o_blank
);
    import bis_pkg::*;

    logic signed [PIXEL_BITS-1:0] eff [NUM_CORNERS];
    logic [NUM_CORNERS-1:0]       missing;
    logic [BANK_SEL_W-1:0]        bsel;
    t_pixel                       pix;
    logic signed [DIFF_W-1:0]     d0;
    logic signed [DIFF_W-1:0]     d1;
    logic signed [FRAC_W:0]       fxs;
    logic signed [V_W-1:0]        p0;
    logic signed [V_W-1:0]        p1;
    logic signed [V_W-1:0]        n_m0;
    logic signed [V_W-1:0]        n_m1;
    logic                         n_blank_mid;

    logic signed [V_W-1:0]        r_m0;
    logic signed [V_W-1:0]        r_m1;
    logic [FRAC_W-1:0]            r_fy;
    logic                         r_blank_mid;

    logic signed [D_W-1:0]        dd;
    logic signed [FRAC_W:0]       fys;
    logic signed [R_W-1:0]        prod;
    logic signed [R_W-1:0]        rsum;
    logic signed [S_W-1:0]        scaled;
    logic signed [S_W-1:0]        rounded;
    logic signed [SAT_W-1:0]      wide;
    logic signed [OUT_W-1:0]      sat_val;
    logic signed [OUT_W-1:0]      blank_out;

    logic signed [OUT_W-1:0]      r_value;
    logic                         r_blank;

    // corner c = dy*2+dx sits in the bank of matching row and column parity
    always_comb begin
        bsel = '0;
        pix  = '0;
        for (int c = 0; c < NUM_CORNERS; c++) begin
            bsel       = {i_meta.iy0 ^ c[1], i_meta.ix0 ^ c[0]};
            pix        = i_bank_data[bsel];
            missing[c] = pix.invalid ||
                         (CMP_W'($signed(pix.value)) == CMP_W'(i_blank_value));
            eff[c]     = pix.invalid ? '0 : pix.value;
        end
    end

    always_comb begin
        fxs  = $signed({1'b0, i_meta.fx});
        d0   = DIFF_W'(eff[1]) - DIFF_W'(eff[0]);
        d1   = DIFF_W'(eff[3]) - DIFF_W'(eff[2]);
        p0   = d0 * fxs;
        p1   = d1 * fxs;
        n_m0 = (V_W'(eff[0]) <<< COORD_FRAC_BITS) + p0;
        n_m1 = (V_W'(eff[2]) <<< COORD_FRAC_BITS) + p1;
        n_blank_mid = i_meta.outside || (&missing);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_mid) begin
            r_m0        <= n_m0;
            r_m1        <= n_m1;
            r_fy        <= i_meta.fy;
            r_blank_mid <= n_blank_mid;
        end
    end

    always_comb begin
        dd      = D_W'(r_m1) - D_W'(r_m0);
        fys     = $signed({1'b0, r_fy});
        prod    = dd * fys;
        rsum    = (R_W'(r_m0) <<< COORD_FRAC_BITS) + prod;
        scaled  = S_W'(rsum) <<< SHL;
        // round half up when the product carries more than 16 fraction bits
        rounded = (scaled + S_W'(RND_C)) >>> SHR;
        wide    = SAT_W'(rounded);
        if (wide > SAT_W'(OUT_MAX)) begin
            sat_val = OUT_MAX;
        end else if (wide < SAT_W'(OUT_MIN)) begin
            sat_val = OUT_MIN;
        end else begin
            sat_val = wide[OUT_W-1:0];
        end
        blank_out = OUT_W'(i_blank_value) <<< OUT_FRAC;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_out) begin
            r_value <= r_blank_mid ? blank_out : sat_val;
            r_blank <= r_blank_mid;
        end
    end

    assign o_value = r_value;
    assign o_blank = r_blank;

endmodule

@@ rtl/bilinear_image_sampler.sv @@
// bilinear_image_sampler: top level, pixel store in four parity banks plus query pipeline
// depends on bis_pkg, bis_if, bis_bank_ram and bis_blend
//
//   channel    dir   transfer carries
//   i_item     in    pixel write (opcode 0) or sample query (opcode 1)
//   i_cfg      in    register write: image width, image height, blank value
//   o_sample   out   interpolated sample and blank flag, one per query
//
// one item per cycle unless the output stalls; query stages: bank read, row blend, output
// the four corners come from four banks split by row and column parity, one
// read port each, so a query costs one read per bank; writes use the write port
// synchronous active-low reset clears the stage valid bits and the config registers;
// the pixel store is not cleared and holds nothing defined until written
// each stage advances when the one after it is empty or moving, so bubbles
// close up and the item channel keeps taking transfers behind a stalled result
module bilinear_image_sampler (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bis_item_if.sink     i_item,
    bis_cfg_if.sink      i_cfg,
    bis_sample_if.source o_sample
);
    import bis_pkg::*;

    logic [DIM_W_X-1:0]              r_img_width;
    logic [DIM_W_Y-1:0]              r_img_height;
    logic signed [VALUE_FIELD_W-1:0] r_blank_value;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic en1;
    logic en2;
    logic en3;
    logic accept;
    logic query_acc;
    logic write_acc;

    t_query_meta n_meta;
    t_query_meta r_meta;
    t_blend_ctrl ctrl;

    logic [EXT_W-1:0] int_x;
    logic [EXT_W-1:0] int_y;
    logic [EXT_W-1:0] ixc;
    logic [EXT_W-1:0] iyc;
    logic [COL_W-1:0] ix;
    logic [COL_W-1:0] ix1;
    logic [ROW_W-1:0] iy;
    logic [ROW_W-1:0] iy1;
    logic [COL_W-1:0] col_sel;
    logic [ROW_W-1:0] row_sel;
    logic [BANK_SEL_W-1:0] bsel;

    logic [BANK_AW-1:0]    rd_addr [NUM_BANKS];
    logic [BANK_AW-1:0]    wr_addr;
    logic [BANK_SEL_W-1:0] wr_bank;
    t_pixel                wr_data;
    t_pixel                bank_data [NUM_BANKS];

    logic [DIM_FIELD_W-1:0] cfg_dim;

    // stage handshake
    assign en3       = !r_v3 || o_sample.ready;
    assign en2       = !r_v2 || en3;
    assign en1       = !r_v1 || en2;
    assign accept    = i_item.valid && en1;
    assign query_acc = accept && (i_item.opcode == OP_QUERY);
    assign write_acc = accept && (i_item.opcode == OP_WRITE) &&
                       (32'(i_item.pixel_col) < MAX_WIDTH) &&
                       (32'(i_item.pixel_row) < MAX_HEIGHT);

    assign i_item.ready = en1;
    assign ctrl.load_mid = en2;
    assign ctrl.load_out = en3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= query_acc;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // configuration
    assign i_cfg.ready = 1'b1;
    assign cfg_dim     = i_cfg.data[DIM_FIELD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width   <= DIM_W_X'(RST_WIDTH);
            r_img_height  <= DIM_W_Y'(RST_HEIGHT);
            r_blank_value <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_IMAGE_WIDTH: begin
                    r_img_width <= DIM_W_X'(clamp_dim(32'(cfg_dim), MAX_WIDTH));
                end
                CFG_IMAGE_HEIGHT: begin
                    r_img_height <= DIM_W_Y'(clamp_dim(32'(cfg_dim), MAX_HEIGHT));
                end
                CFG_BLANK_VALUE: begin
                    r_blank_value <= $signed(i_cfg.data[VALUE_FIELD_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // query decode: floor, clamp to the last full cell, fractions up to 2
    always_comb begin
        int_x = EXT_W'(i_item.coord_x[COORD_W-2:COORD_FRAC_BITS]);
        int_y = EXT_W'(i_item.coord_y[COORD_W-2:COORD_FRAC_BITS]);

        ixc = (int_x >= EXT_W'(r_img_width) - EXT_W'(1)) ?
              EXT_W'(r_img_width) - EXT_W'(2) : int_x;
        iyc = (int_y >= EXT_W'(r_img_height) - EXT_W'(1)) ?
              EXT_W'(r_img_height) - EXT_W'(2) : int_y;

        ix  = ixc[COL_W-1:0];
        iy  = iyc[ROW_W-1:0];
        ix1 = ix + COL_W'(1);
        iy1 = iy + ROW_W'(1);

        n_meta.outside = i_item.coord_x[COORD_W-1] || i_item.coord_y[COORD_W-1] ||
                         (int_x >= EXT_W'(r_img_width)) ||
                         (int_y >= EXT_W'(r_img_height));
        n_meta.ix0 = ix[0];
        n_meta.iy0 = iy[0];
        n_meta.fx  = {int_x != ixc, i_item.coord_x[COORD_FRAC_BITS-1:0]};
        n_meta.fy  = {int_y != iyc, i_item.coord_y[COORD_FRAC_BITS-1:0]};
    end

    // each bank reads whichever of the two corner rows and columns has its parity
    always_comb begin
        bsel    = '0;
        col_sel = '0;
        row_sel = '0;
        for (int b = 0; b < NUM_BANKS; b++) begin
            bsel       = BANK_SEL_W'(b);
            row_sel    = (iy[0] == bsel[1]) ? iy : iy1;
            col_sel    = (ix[0] == bsel[0]) ? ix : ix1;
            rd_addr[b] = BANK_AW'(32'(row_sel >> 1) * BANK_COLS + 32'(col_sel >> 1));
        end
    end

    assign wr_addr = BANK_AW'(32'(i_item.pixel_row >> 1) * BANK_COLS +
                              32'(i_item.pixel_col >> 1));
    assign wr_bank = {i_item.pixel_row[0], i_item.pixel_col[0]};
    assign wr_data.invalid = i_item.pixel_invalid;
    assign wr_data.value   = fit_pixel(i_item.pixel_value);

    for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
        bis_bank_ram #(
            .DEPTH (BANK_DEPTH),
            .WIDTH (PIX_W)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (write_acc && (wr_bank == BANK_SEL_W'(g))),
            .i_waddr (wr_addr),
            .i_wdata (wr_data),
            .i_re    (en1),
            .i_raddr (rd_addr[g]),
            .o_rdata (bank_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_meta <= n_meta;
        end
    end

    bis_blend u_blend (
        .i_clk         (i_clk),
        .i_ctrl        (ctrl),
        .i_meta        (r_meta),
        .i_bank_data   (bank_data),
        .i_blank_value (r_blank_value),
        .o_value       (o_sample.sample_value),
        .o_blank       (o_sample.sample_blank)
    );

    assign o_sample.valid = r_v3;

endmodule

@@ rtl/bis_checker.sv @@
// bis_checker: port-level assertions on the bilinear image sampler
// attached to the top level by the bind statement at the end of this file
// depends on bis_pkg
module bis_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_item_ready,
    input logic                              i_cfg_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [bis_pkg::OUT_W-1:0]  i_out_value,
    input logic                              i_out_blank
);
    import bis_pkg::*;

    // no result comes out of reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_value) && $stable(i_out_blank))
        else $error("stalled result changed");

    // a blank answer, the blank value scaled to 16 fraction bits, has a zero fraction
    a_blank_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_blank |-> (i_out_value[OUT_FRAC-1:0] == '0))
        else $error("blank result with nonzero fraction");

    // with the output register empty the pipeline can always take a transfer
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_item_ready && i_cfg_ready)
        else $error("item channel blocked with empty output");

endmodule

bind bilinear_image_sampler bis_checker u_bis_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_item_ready (i_item.ready),
    .i_cfg_ready  (i_cfg.ready),
    .i_out_valid  (o_sample.valid),
    .i_out_ready  (o_sample.ready),
    .i_out_value  (o_sample.sample_value),
    .i_out_blank  (o_sample.sample_blank)
);

@@ verif/tb_bilinear_image_sampler.sv @@
`timescale 1ns / 1ps
// tb_bilinear_image_sampler: self-checking bench for the bilinear image sampler
// directed rows, then random phases over image size and blank value, checked by a
// local predictor of the pixel store and blend; depends on bis_pkg, bis_if and the RTL
module tb_bilinear_image_sampler;
    import bis_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RST_CYCLES      = 6;
    localparam int SETTLE_CYCLES   = 8;
    // longest quiet stretch of a correct run is a source gap, a sink stall and the
    // three-stage pipeline; the limit is far above that
    localparam int IDLE_LIMIT      = 2000;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int NUM_PHASES      = 9;
    localparam int NUM_FIXED_PH    = 5;
    localparam int NUM_DIR_ROWS    = 23;
    localparam int STORE_DEPTH     = MAX_WIDTH * MAX_HEIGHT;
    localparam int ONE_PX          = 1 << COORD_FRAC_BITS;
    localparam int COORD_MAX       = (1 << (COORD_W - 1)) - 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam logic signed [VALUE_FIELD_W-1:0] VAL_MAX = {1'b0, {(VALUE_FIELD_W-1){1'b1}}};
    localparam logic signed [VALUE_FIELD_W-1:0] VAL_MIN = {1'b1, {(VALUE_FIELD_W-1){1'b0}}};

    typedef struct packed {
        t_opcode                         op;
        logic [PIX_POS_W-1:0]            col;
        logic [PIX_POS_W-1:0]            row;
        logic signed [VALUE_FIELD_W-1:0] value;
        logic                            inv;
        logic signed [COORD_W-1:0]       cx;
        logic signed [COORD_W-1:0]       cy;
    } t_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    blank;
    } t_sample_exp;

    typedef struct packed {
        t_item       item;
        logic        chk;
        t_sample_exp want;
    } t_dir_row;

    // runs at reset geometry 512 x 512 with blank value 0
    localparam t_dir_row DIR_ROWS [NUM_DIR_ROWS] = '{
        '{'{OP_WRITE, 9'd0, 9'd0, 16'sd100, 1'b0, 18'sd0, 18'sd0}, 1'b0, '0},
        '{'{OP_WRITE, 9'd1, 9'd0, 16'sd200, 1'b0, 18'sh20000, 18'sd131071}, 1'b0, '0},
        '{'{OP_WRITE, 9'd0, 9'd1, 16'sd300, 1'b0, 18'sd0, 18'sd0}, 1'b0, '0},
        '{'{OP_WRITE, 9'd1, 9'd1, 16'sd400, 1'b0, 18'sd0, 18'sd0}, 1'b0, '0},
        '{'{OP_QUERY, 9'd0, 9'd0, 16'sd0, 1'b0, 18'sd0, 18'sd0},
          1'b1, '{40'sd6553600, 1'b0}},
        '{'{OP_QUERY, 9'd511, 9'd511, 16'sh8000, 1'b1, 18'sd128, 18'sd128},
          1'b1, '{40'sd16384000, 1'b0}},
        // outside the image at negative x, negative y or both
        '{'{OP_QUERY, 9'd0, 9'd0, 16'sd0, 1'b0, -18'sd1, 18'sd0}, 1'b1, '{40'sd0, 1'b1}},
        '{'{OP_QUERY, 9'd0, 9'd0, 16'sd0, 1'b0, 18'sh20000, 18'sh20000},
          1'b1, '{40'sd0, 1'b1}},
        '{'{OP_QUERY, 9'd0, 9'd0, 16'sd0, 1'b0, 18'sd128, -18'sd1}, 1'b1, '{40'sd0, 1'b1}},
        // far corner with extreme values, one corner invalid
        '{'{OP_WRITE, 9'd510, 9'd510, 16'sh8000, 1'b0, 18'sd0, 18'sd0}, 1'b0, '0},
        '{'{OP_WRITE, 9'd511, 9'd510, 16'sh7fff, 1'b0, 18'sd0, 18'sd0}, 1'b0, '0},
        '{'{OP_WRITE, 9'd510, 9'd511, 16'sh7fff, 1'b0, 18'sd0, 18'sd0}, 1'b0, '0},
        '{'{OP_WRITE, 9'd511, 9'd511, 16'sh8000, 1'b1, 18'sd0, 18'sd0}, 1'b0, '0},
        '{'{OP_QUERY, 9'd0, 9'd0, 16'sd0, 1'b0, 18'sd131071, 18'sd131071}, 1'b0, '0},
        '{'{OP_QUERY, 9'd0, 9'd0, 16'sd0, 1'b0, 18'sd130560, 18'sd130816}, 1'b0, '0},
        // cell whose corners are all blank or invalid
        '{'{OP_WRITE, 9'd10, 9'd10, 16'sd0, 1'b0, 18'sd0, 18'sd0}, 1'b0, '0},
        '{'{OP_WRITE, 9'd11, 9'd10, 16'sd1234, 1'b1, 18'sd0, 18'sd0}, 1'b0, '0},
        '{'{OP_WRITE, 9'd10, 9'd11, 16'sd0, 1'b0, 18'sd0, 18'sd0}, 1'b0, '0},
        '{'{OP_WRITE, 9'd11, 9'd11, -16'sd5, 1'b1, 18'sd0, 18'sd0}, 1'b0, '0},
        '{'{OP_QUERY, 9'd0, 9'd0, 16'sd0, 1'b0, 18'sd2688, 18'sd2624},
          1'b1, '{40'sd0, 1'b1}},
        // one corner neither blank nor invalid, so the blend runs with invalid corners as zero
        '{'{OP_WRITE, 9'd11, 9'd11, 16'sd500, 1'b0, 18'sd77, 18'sd99}, 1'b0, '0},
        '{'{OP_QUERY, 9'd0, 9'd0, 16'sd0, 1'b0, 18'sd2560, 18'sd2560},
          1'b1, '{40'sd0, 1'b0}},
        '{'{OP_QUERY, 9'd3, 9'd4, 16'sd9, 1'b1, 18'sd2815, 18'sd2815}, 1'b0, '0}
    };

    localparam logic [CFG_DATA_W-1:0] PH_W [NUM_FIXED_PH] =
        '{16'd2, 16'd512, 16'd1023, 16'hfc01, 16'd3};
    localparam logic [CFG_DATA_W-1:0] PH_H [NUM_FIXED_PH] =
        '{16'd2, 16'd512, 16'd0, 16'd512, 16'd5};
    localparam logic [CFG_DATA_W-1:0] PH_BLANK [NUM_FIXED_PH] =
        '{16'h8000, 16'h7fff, 16'h0003, 16'hffff, 16'h0000};

    logic i_clk;
    logic i_rst_n;

    bis_item_if   item_bus ();
    bis_cfg_if    cfg_bus ();
    bis_sample_if sample_bus ();

    bilinear_image_sampler u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .i_cfg    (cfg_bus),
        .o_sample (sample_bus)
    );

    // mirror of the pixel store and the registers
    t_pixel image_mem [STORE_DEPTH];
    bit     image_written [STORE_DEPTH];
    int     img_w = RST_WIDTH;
    int     img_h = RST_HEIGHT;
    logic signed [CFG_DATA_W-1:0] blank_val = '0;

    t_sample_exp sample_q [$];
    int n_errors    = 0;
    int idle_cycles = 0;
    int items_sent  = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // result side backpressure
    initial begin
        sample_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                sample_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            sample_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_samples
        t_sample_exp want;
        if (i_rst_n && sample_bus.valid && sample_bus.ready) begin
            if (sample_q.size() == 0) begin
                $error("sample transfer with no query outstanding");
                n_errors++;
            end else begin
                want = sample_q.pop_front();
                if (sample_bus.sample_value !== want.value) begin
                    $error("sample_value: expected %0d, got %0d",
                           want.value, sample_bus.sample_value);
                    n_errors++;
                end
                if (sample_bus.sample_blank !== want.blank) begin
                    $error("sample_blank: expected %0d, got %0d",
                           want.blank, sample_bus.sample_blank);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((item_bus.valid && item_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
                     (sample_bus.valid && sample_bus.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic int dim_of(logic [CFG_DATA_W-1:0] data, int maxv);
        int v;
        v = int'(data[DIM_FIELD_W-1:0]);
        if (v < 2) begin
            v = 2;
        end else if (v > maxv) begin
            v = maxv;
        end
        return v;
    endfunction

    // top-left corner of the cell, pulled in from the last column and row
    function automatic void locate_cell(logic signed [COORD_W-1:0] cx,
                                        logic signed [COORD_W-1:0] cy,
                                        output int ix, output int iy);
        ix = int'(cx >>> COORD_FRAC_BITS);
        iy = int'(cy >>> COORD_FRAC_BITS);
        if (ix >= img_w - 1) begin
            ix = img_w - 2;
        end
        if (iy >= img_h - 1) begin
            iy = img_h - 2;
        end
    endfunction

    function automatic t_sample_exp predict_sample(logic signed [COORD_W-1:0] cx,
                                                   logic signed [COORD_W-1:0] cy);
        t_sample_exp e;
        t_pixel      p;
        int          ix, iy, shr;
        longint      fx, fy, w0, w1, acc;
        longint      v [NUM_CORNERS];
        bit          all_missing;
        e.blank = 1'b1;
        e.value = OUT_W'(longint'(blank_val) <<< OUT_FRAC);
        if (cx < 0 || longint'(cx) >= longint'(img_w) * ONE_PX ||
            cy < 0 || longint'(cy) >= longint'(img_h) * ONE_PX) begin
            return e;
        end
        locate_cell(cx, cy, ix, iy);
        fx = longint'(cx) - longint'(ix) * ONE_PX;
        fy = longint'(cy) - longint'(iy) * ONE_PX;
        all_missing = 1'b1;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            p = image_mem[(iy + k / 2) * MAX_WIDTH + ix + k % 2];
            if (!p.invalid && p.value != blank_val) begin
                all_missing = 1'b0;
            end
            if (p.invalid) begin
                v[k] = 0;
            end else begin
                v[k] = p.value;
            end
        end
        if (all_missing) begin
            return e;
        end
        w0  = v[0] * (ONE_PX - fx) + v[1] * fx;
        w1  = v[2] * (ONE_PX - fx) + v[3] * fx;
        acc = w0 * (ONE_PX - fy) + w1 * fy;
        if (2 * COORD_FRAC_BITS <= OUT_FRAC) begin
            acc = acc <<< (OUT_FRAC - 2 * COORD_FRAC_BITS);
        end else begin
            // round half up
            shr = 2 * COORD_FRAC_BITS - OUT_FRAC;
            acc = (acc + (longint'(1) <<< (shr - 1))) >>> shr;
        end
        if (acc > OUT_MAX) begin
            acc = OUT_MAX;
        end else if (acc < OUT_MIN) begin
            acc = OUT_MIN;
        end
        e.blank = 1'b0;
        e.value = acc[OUT_W-1:0];
        return e;
    endfunction

    function automatic void store_pixel(t_item it);
        int a;
        if (it.col < MAX_WIDTH && it.row < MAX_HEIGHT) begin
            a = int'(it.row) * MAX_WIDTH + int'(it.col);
            image_mem[a].value   = PIXEL_BITS'(it.value);
            image_mem[a].invalid = it.inv;
            image_written[a]     = 1'b1;
        end
    endfunction

    function automatic logic signed [VALUE_FIELD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1:    return blank_val;
            2:       return VAL_MAX;
            3:       return VAL_MIN;
            4:       return VALUE_FIELD_W'(int'($urandom_range(0, 8)) - 4);
            default: return VALUE_FIELD_W'($urandom);
        endcase
    endfunction

    // in-range position along one axis, leaning toward the last cell and the grid
    function automatic logic signed [COORD_W-1:0] pick_axis(int dim);
        case ($urandom_range(0, 9))
            0, 1:    return COORD_W'((dim - 1) * ONE_PX + $urandom_range(0, ONE_PX - 1));
            2:       return COORD_W'($urandom_range(0, dim - 1) * ONE_PX);
            default: return COORD_W'($urandom_range(0, dim * ONE_PX - 1));
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] outside_axis(int dim);
        if ($urandom_range(0, 1) == 0 || dim * ONE_PX > COORD_MAX) begin
            return -COORD_W'($urandom_range(1, COORD_MAX + 1));
        end
        return COORD_W'($urandom_range(dim * ONE_PX, COORD_MAX));
    endfunction

    function automatic t_item noise_item(t_opcode op);
        t_item it;
        it.op    = op;
        it.col   = PIX_POS_W'($urandom);
        it.row   = PIX_POS_W'($urandom);
        it.value = VALUE_FIELD_W'($urandom);
        it.inv   = 1'($urandom);
        it.cx    = COORD_W'($urandom);
        it.cy    = COORD_W'($urandom);
        return it;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_dim();
        case ($urandom_range(0, 9))
            7:       return CFG_DATA_W'($urandom_range(0, 1023));
            8:       return CFG_DATA_W'($urandom_range(13, 64));
            9:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(2, 12));
        endcase
    endfunction

    task automatic issue(input t_item it, input bit given, input t_sample_exp want);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        item_bus.valid         <= 1'b1;
        item_bus.opcode        <= it.op;
        item_bus.pixel_col     <= it.col;
        item_bus.pixel_row     <= it.row;
        item_bus.pixel_value   <= it.value;
        item_bus.pixel_invalid <= it.inv;
        item_bus.coord_x       <= it.cx;
        item_bus.coord_y       <= it.cy;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        items_sent++;
        if (it.op == OP_WRITE) begin
            store_pixel(it);
        end else if (given) begin
            sample_q.push_back(want);
        end else begin
            sample_q.push_back(predict_sample(it.cx, it.cy));
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        if (idx == CFG_IMAGE_WIDTH) begin
            img_w = dim_of(data, MAX_WIDTH);
        end else if (idx == CFG_IMAGE_HEIGHT) begin
            img_h = dim_of(data, MAX_HEIGHT);
        end else if (idx == CFG_BLANK_VALUE) begin
            blank_val = data;
        end
    endtask

    // hold the source until every sample is back and trailing writes have landed
    task automatic drain();
        item_bus.valid <= 1'b0;
        while (sample_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write the corners a query needs that are unwritten or picked for refill, then the query
    task automatic query_cell();
        t_item q, w;
        int    ix, iy, col, row;
        bit    refill, hole;
        q = noise_item(OP_QUERY);
        q.cx = pick_axis(img_w);
        q.cy = pick_axis(img_h);
        locate_cell(q.cx, q.cy, ix, iy);
        refill = $urandom_range(0, 9) < 6;
        hole   = $urandom_range(0, 6) == 0;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            col = ix + k % 2;
            row = iy + k / 2;
            if (refill || !image_written[row * MAX_WIDTH + col]) begin
                w = noise_item(OP_WRITE);
                w.col   = PIX_POS_W'(col);
                w.row   = PIX_POS_W'(row);
                w.value = pick_value();
                w.inv   = $urandom_range(0, 4) == 0;
                if (hole) begin
                    if ($urandom_range(0, 1) == 0) begin
                        w.inv = 1'b1;
                    end else begin
                        w.inv   = 1'b0;
                        w.value = blank_val;
                    end
                end
                issue(w, 1'b0, '0);
            end
        end
        issue(q, 1'b0, '0);
    endtask

    task automatic run_phase(input int n);
        t_item it;
        int    start;
        start = items_sent;
        while (items_sent - start < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    query_cell();
                end
                5, 6: begin
                    it = noise_item(OP_QUERY);
                    if ($urandom_range(0, 1) == 0) begin
                        it.cx = pick_axis(img_w);
                        it.cy = pick_axis(img_h);
                    end
                    case ($urandom_range(0, 2))
                        0: it.cx = outside_axis(img_w);
                        1: it.cy = outside_axis(img_h);
                        default: begin
                            it.cx = outside_axis(img_w);
                            it.cy = outside_axis(img_h);
                        end
                    endcase
                    issue(it, 1'b0, '0);
                end
                default: begin
                    it = noise_item(OP_WRITE);
                    if ($urandom_range(0, 1) == 0) begin
                        it.col = PIX_POS_W'($urandom_range(0, img_w - 1));
                        it.row = PIX_POS_W'($urandom_range(0, img_h - 1));
                    end
                    it.value = pick_value();
                    it.inv   = $urandom_range(0, 4) == 0;
                    issue(it, 1'b0, '0);
                end
            endcase
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] wd, hd, bd;
        item_bus.valid         <= 1'b0;
        item_bus.opcode        <= OP_WRITE;
        item_bus.pixel_col     <= '0;
        item_bus.pixel_row     <= '0;
        item_bus.pixel_value   <= '0;
        item_bus.pixel_invalid <= 1'b0;
        item_bus.coord_x       <= '0;
        item_bus.coord_y       <= '0;
        cfg_bus.valid          <= 1'b0;
        cfg_bus.index          <= CFG_IMAGE_WIDTH;
        cfg_bus.data           <= '0;
        i_rst_n                <= 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_pct   = 20;
        stall_pct = 20;
        for (int i = 0; i < NUM_DIR_ROWS; i++) begin
            issue(DIR_ROWS[i].item, DIR_ROWS[i].chk, DIR_ROWS[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            if (p < NUM_FIXED_PH) begin
                wd = PH_W[p];
                hd = PH_H[p];
                bd = PH_BLANK[p];
            end else begin
                wd = rand_dim();
                hd = rand_dim();
                if ($urandom_range(0, 1) == 0) begin
                    bd = CFG_DATA_W'(int'($urandom_range(0, 8)) - 4);
                end else begin
                    bd = CFG_DATA_W'($urandom);
                end
            end
            write_reg(CFG_IMAGE_WIDTH, wd);
            write_reg(CFG_IMAGE_HEIGHT, hd);
            write_reg(CFG_BLANK_VALUE, bd);
            // unmapped index must leave every register alone
            if (p == 2 || p == 6) begin
                write_reg(CFG_SPARE_INDEX, CFG_DATA_W'($urandom));
            end
            cfg_bus.valid <= 1'b0;
            if (p == NUM_PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            end
            run_phase(ITEMS_PER_PHASE);
        end
        drain();

        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/bis_pkg.sv
rtl/bis_if.sv
rtl/bis_bank_ram.sv
rtl/bis_blend.sv
rtl/bilinear_image_sampler.sv
rtl/bis_checker.sv
verif/tb_bilinear_image_sampler.sv
